@@ hw/rtl/stksr_pkg.sv @@
// ----------------------------------------------------------------------------
// stksr_pkg
// shared codes and types for the stack with sort and reverse
// ----------------------------------------------------------------------------
package stksr_pkg;

   localparam int OPCODE_W = 3;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;
   localparam int CAP_W    = 5;
   localparam int IO_W     = 32;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   localparam logic [OPCODE_W-1:0] OP_PUSH    = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_POP     = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_PEEK    = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_SORT    = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_REVERSE = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

   localparam logic CSR_IDX_CAPACITY = 1'b0;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

   localparam int UNDERFLOW_INT = -128;

   typedef struct packed {
      logic [IO_W-1:0]     value;
      logic [STATUS_W-1:0] status;
   } fin_type;

endpackage

@@ hw/rtl/stksr_ram.sv @@
// ----------------------------------------------------------------------------
// stksr_ram
// entry store: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module stksr_ram #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_WIDTH-1:0]    wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_WIDTH-1:0]    rd_data
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/stksr_minmax.sv @@
// ----------------------------------------------------------------------------
// stksr_minmax
// signed compare unit, splits two words into smaller and larger
// ----------------------------------------------------------------------------
module stksr_minmax #(
   parameter int DATA_WIDTH = 32
) (
   input  logic [DATA_WIDTH-1:0] held_word,
   input  logic [DATA_WIDTH-1:0] new_word,
   output logic [DATA_WIDTH-1:0] min_word,
   output logic [DATA_WIDTH-1:0] max_word
);

   logic new_less;

   assign new_less = $signed(new_word) < $signed(held_word);

   always_comb begin
      if (new_less) begin
         min_word = new_word;
         max_word = held_word;
      end else begin
         min_word = held_word;
         max_word = new_word;
      end
   end

endmodule

@@ hw/rtl/stack_with_sort_and_reverse.sv @@
// ----------------------------------------------------------------------------
// stack_with_sort_and_reverse
// bounded lifo of signed words with in-place sort and reverse
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  opcode, push_value
//   rsp      out        rsp_valid/rsp_ready  read_value, status, count, flags
//   csr      in/out     apb, pready high     capacity at byte address 0
//
// push and refused ops finish from idle; pop and peek add S_READ (registered store read)
// reverse swaps entry pairs from both ends inward via S_RB, S_RC, S_RD (one store write port)
// sort is a bubble pass loop over the single compare unit: passes with last
//   index k = n-1 down to 1, each pass through S_SLOAD, S_SCMP per pair, S_SEND
// reset clears count, control and capacity (16); the store is not cleared
// a finished item waits in a holding register while the output is occupied
// ----------------------------------------------------------------------------
module stack_with_sort_and_reverse
   import stksr_pkg::*;
#(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [OPCODE_W-1:0]        req_opcode,
   input  logic signed [IO_W-1:0]     req_push_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [IO_W-1:0]     rsp_read_value,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [COUNT_W-1:0]         rsp_entry_count,
   output logic                       rsp_is_empty,
   output logic                       rsp_is_full,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [CSR_AW-1:0]          csr_paddr,
   input  logic [CSR_DW-1:0]          csr_pwdata,
   output logic [CSR_DW-1:0]          csr_prdata,
   output logic                       csr_pready
);

   localparam int MAXN = (DEPTH < 31) ? DEPTH : 31;
   localparam int CW   = $clog2(MAXN + 1);
   localparam int AW   = $clog2(DEPTH);
   localparam logic [DATA_WIDTH-1:0] UNDERFLOW_WORD = DATA_WIDTH'(UNDERFLOW_INT);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_READ  = 4'd1;
   localparam logic [3:0] S_SLOAD = 4'd2;
   localparam logic [3:0] S_SCMP  = 4'd3;
   localparam logic [3:0] S_SEND  = 4'd4;
   localparam logic [3:0] S_RB    = 4'd5;
   localparam logic [3:0] S_RC    = 4'd6;
   localparam logic [3:0] S_RD    = 4'd7;
   localparam logic [3:0] S_DONE  = 4'd8;

   logic [3:0]            state_ff, state_in;
   logic [CW-1:0]         held_count_ff, held_count_in;
   logic [CAP_W-1:0]      capacity_ff, capacity_in;
   logic [CW-1:0]         idx_ff, idx_in;
   logic [CW-1:0]         last_ff, last_in;
   logic [DATA_WIDTH-1:0] cur_ff, cur_in;
   fin_type               res_ff, res_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [IO_W-1:0]       rsp_value_ff, rsp_value_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]    rsp_count_ff, rsp_count_in;
   logic                  rsp_empty_ff, rsp_empty_in;
   logic                  rsp_full_ff, rsp_full_in;

   logic                  acc;
   logic                  out_free;
   logic                  csr_wr;
   logic [CW-1:0]         cap_eff;
   logic [CW-1:0]         held_inc, held_dec, idx_inc, idx_dec, last_dec;
   logic                  fin_valid;
   fin_type               fin;

   logic                  ram_we, ram_re;
   logic [AW-1:0]         ram_waddr, ram_raddr;
   logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;
   logic [DATA_WIDTH-1:0] mm_min, mm_max;

   stksr_ram #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   stksr_minmax #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_minmax (
      .held_word (cur_ff),
      .new_word  (ram_rdata),
      .min_word  (mm_min),
      .max_word  (mm_max)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign acc       = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign held_inc = held_count_ff + CW'(1);
   assign held_dec = held_count_ff - CW'(1);
   assign idx_inc  = idx_ff + CW'(1);
   assign idx_dec  = idx_ff - CW'(1);
   assign last_dec = last_ff - CW'(1);

   // effective capacity, clamped to 1..min(depth, 31)
   always_comb begin
      if (capacity_ff == '0) begin
         cap_eff = CW'(1);
      end else if (int'(capacity_ff) > MAXN) begin
         cap_eff = CW'(MAXN);
      end else begin
         cap_eff = CW'(capacity_ff);
      end
   end

   // csr port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      capacity_in = capacity_ff;
      if (csr_wr && (csr_paddr[2] == CSR_IDX_CAPACITY)) begin
         capacity_in = csr_pwdata[CAP_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == CSR_IDX_CAPACITY) ? CSR_DW'(capacity_ff) : '0;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      held_count_in = held_count_ff;
      idx_in        = idx_ff;
      last_in       = last_ff;
      cur_in        = cur_ff;
      res_in        = res_ff;
      fin_valid     = 1'b0;
      fin           = '0;
      ram_we        = 1'b0;
      ram_waddr     = '0;
      ram_wdata     = '0;
      ram_re        = 1'b0;
      ram_raddr     = '0;

      case (state_ff)
         S_IDLE: begin
            if (acc) begin
               case (req_opcode)
                  OP_PUSH: begin
                     fin_valid = 1'b1;
                     if (held_count_ff >= cap_eff) begin
                        fin.status = ST_OVERFLOW;
                     end else begin
                        ram_we        = 1'b1;
                        ram_waddr     = AW'(held_count_ff);
                        ram_wdata     = DATA_WIDTH'(req_push_value);
                        held_count_in = held_inc;
                     end
                  end
                  OP_POP, OP_PEEK: begin
                     if (held_count_ff == '0) begin
                        fin_valid  = 1'b1;
                        fin.value  = IO_W'(UNDERFLOW_WORD);
                        fin.status = ST_UNDERFLOW;
                     end else begin
                        ram_re    = 1'b1;
                        ram_raddr = AW'(held_dec);
                        if (req_opcode == OP_POP) begin
                           held_count_in = held_dec;
                        end
                        state_in = S_READ;
                     end
                  end
                  OP_SORT: begin
                     if (held_count_ff < CW'(2)) begin
                        fin_valid = 1'b1;
                     end else begin
                        last_in  = held_dec;
                        ram_re   = 1'b1;
                        state_in = S_SLOAD;
                     end
                  end
                  OP_REVERSE: begin
                     if (held_count_ff < CW'(2)) begin
                        fin_valid = 1'b1;
                     end else begin
                        idx_in   = '0;
                        last_in  = held_dec;
                        ram_re   = 1'b1;
                        state_in = S_RB;
                     end
                  end
                  default: begin
                     fin_valid = 1'b1;
                  end
               endcase
            end
         end
         S_READ: begin
            fin_valid = 1'b1;
            fin.value = IO_W'(ram_rdata);
         end
         S_SLOAD: begin
            cur_in    = ram_rdata;
            idx_in    = CW'(1);
            ram_re    = 1'b1;
            ram_raddr = AW'(1);
            state_in  = S_SCMP;
         end
         S_SCMP: begin
            ram_we    = 1'b1;
            ram_waddr = AW'(idx_dec);
            ram_wdata = mm_min;
            cur_in    = mm_max;
            if (idx_ff == last_ff) begin
               state_in = S_SEND;
            end else begin
               idx_in    = idx_inc;
               ram_re    = 1'b1;
               ram_raddr = AW'(idx_inc);
            end
         end
         S_SEND: begin
            ram_we    = 1'b1;
            ram_waddr = AW'(last_ff);
            ram_wdata = cur_ff;
            if (last_ff == CW'(1)) begin
               fin_valid = 1'b1;
            end else begin
               last_in  = last_dec;
               ram_re   = 1'b1;
               state_in = S_SLOAD;
            end
         end
         S_RB: begin
            cur_in    = ram_rdata;
            ram_re    = 1'b1;
            ram_raddr = AW'(last_ff);
            state_in  = S_RC;
         end
         S_RC: begin
            ram_we    = 1'b1;
            ram_waddr = AW'(idx_ff);
            ram_wdata = ram_rdata;
            state_in  = S_RD;
         end
         S_RD: begin
            ram_we    = 1'b1;
            ram_waddr = AW'(last_ff);
            ram_wdata = cur_ff;
            if (idx_inc < last_dec) begin
               idx_in    = idx_inc;
               last_in   = last_dec;
               ram_re    = 1'b1;
               ram_raddr = AW'(idx_inc);
               state_in  = S_RB;
            end else begin
               fin_valid = 1'b1;
            end
         end
         S_DONE: begin
            fin_valid = 1'b1;
            fin       = res_ff;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (fin_valid) begin
         if (out_free) begin
            state_in = S_IDLE;
         end else begin
            res_in   = fin;
            state_in = S_DONE;
         end
      end
   end

   // output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_full_in   = rsp_full_ff;
      if (fin_valid && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = fin.value;
         rsp_status_in = fin.status;
         rsp_count_in  = COUNT_W'(held_count_in);
         rsp_empty_in  = (held_count_in == '0);
         rsp_full_in   = (held_count_in >= cap_eff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         held_count_ff <= '0;
         capacity_ff   <= CAPACITY_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         held_count_ff <= held_count_in;
         capacity_ff   <= capacity_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      last_ff       <= last_in;
      cur_ff        <= cur_in;
      res_ff        <= res_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_full_ff   <= rsp_full_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = rsp_value_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_is_empty    = rsp_empty_ff;
   assign rsp_is_full     = rsp_full_ff;

`ifndef SYNTHESIS
   a_write_below_count: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (32'(ram_waddr) < 32'(held_count_in)))
      else $error("store write outside held entries");

   a_pop_drops_one: assert property (@(posedge clock) disable iff (reset)
      (acc && (req_opcode == OP_POP) && (held_count_ff != '0))
      |=> (held_count_ff == $past(held_dec)))
      else $error("pop did not drop the count by one");

   a_full_push_holds: assert property (@(posedge clock) disable iff (reset)
      (acc && (req_opcode == OP_PUSH) && (held_count_ff >= cap_eff))
      |=> $stable(held_count_ff))
      else $error("refused push changed the count");

   a_done_waits_output: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |-> rsp_valid_ff)
      else $error("held result while output is free");
`endif

endmodule
